FILE: src/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define BMR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// cause in one cycle implies effect in the next
`define BMR_ASSERT_NEXT(lbl, clk, rst_n, cause, effect) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error("assertion failed");

`endif

FILE: src/bmr_pkg.sv
`default_nettype none
package bmr_pkg;

    localparam int MAX_WIDTH       = 64;
    localparam int MAX_HALF_KERNEL = 7;

    typedef enum logic [1:0] {
        KIND_DIL,
        KIND_ERO,
        KIND_GRAD
    } t_kind;

    localparam logic [1:0] REG_OP_MODE = 2'd0;
    localparam logic [1:0] REG_WIDTH   = 2'd1;
    localparam logic [1:0] REG_KHW     = 2'd2;
    localparam logic [1:0] REG_KHH     = 2'd3;

    localparam logic [2:0] OP_DILATE   = 3'd0;
    localparam logic [2:0] OP_ERODE    = 3'd1;
    localparam logic [2:0] OP_CLOSE    = 3'd2;
    localparam logic [2:0] OP_OPEN     = 3'd3;
    localparam logic [2:0] OP_GRADIENT = 3'd4;

endpackage
`default_nettype wire

FILE: src/bmr_cell.sv
`default_nettype none
module bmr_cell #(
    parameter int W = bmr_pkg::MAX_WIDTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_shift,
    input  wire logic         i_push_view,
    input  wire logic         i_sel,
    input  wire logic [W-1:0] i_mask,
    input  wire logic [W-1:0] i_left,
    output logic      [W-1:0] o_row,
    output logic      [W-1:0] o_or,
    output logic      [W-1:0] o_and
);
    import bmr_pkg::*;

    logic [W-1:0] r_row;
    logic [W-1:0] view;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_row <= i_left;
        end
    end

    // window entry as seen after a push, or as held during a flush
    assign view  = i_push_view ? i_left : r_row;
    assign o_row = r_row;
    assign o_or  = i_sel ? (view & i_mask) : '0;
    assign o_and = i_sel ? view : '1;

endmodule
`default_nettype wire

FILE: src/bmr_stage.sv
`default_nettype none
`include "assert_macros.svh"
module bmr_stage #(
    parameter int W = bmr_pkg::MAX_WIDTH,
    parameter int K = bmr_pkg::MAX_HALF_KERNEL,
    localparam int D  = 2 * K + 1,
    localparam int SW = $clog2(D + 1),
    localparam int KW = $clog2(K + 1)
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire bmr_pkg::t_kind i_kind,
    input  wire logic [W-1:0]   i_mask,
    input  wire logic [KW-1:0]  i_kw,
    input  wire logic [KW-1:0]  i_kh,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic [W-1:0]   i_row,
    input  wire logic           i_end,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic      [W-1:0]   o_row,
    output logic                o_last
);
    import bmr_pkg::*;

    logic [SW-1:0] r_seen;
    logic          r_flush;
    logic [KW-1:0] r_j;
    logic [1:0]    r_cnt;
    logic [W-1:0]  r_q_row [2];
    logic          r_q_last [2];

    logic [W-1:0]  left   [D];
    logic [W-1:0]  rows   [D];
    logic [W-1:0]  t_or   [D];
    logic [W-1:0]  t_and  [D];
    logic [D-1:0]  sel;

    logic          space, accept, fire, push, pop, wr_idx;
    logic [SW-1:0] v_next, view_v;
    logic [KW-1:0] view_j;
    logic [SW:0]   lo, hi;
    logic [W-1:0]  vor, vand, res;
    logic          res_last;

    function automatic logic [W-1:0] hdil(input logic [W-1:0] x, input logic [KW-1:0] kw,
                                          input logic [W-1:0] m);
        logic [W-1:0] acc;
        acc = x;
        for (int d = 1; d <= K; d++) begin
            if (d <= int'(kw)) acc = acc | (x << d) | (x >> d);
        end
        return acc & m;
    endfunction

    function automatic logic [W-1:0] hero(input logic [W-1:0] x, input logic [KW-1:0] kw,
                                          input logic [W-1:0] m);
        logic [W-1:0] v, nv, acc;
        v   = x | ~m;
        nv  = ~v;
        acc = v;
        for (int d = 1; d <= K; d++) begin
            if (d <= int'(kw)) acc = acc & ~(nv << d) & ~(nv >> d);
        end
        return acc & m;
    endfunction

    assign space   = (r_cnt != 2'd2);
    assign o_ready = !r_flush && space;
    assign accept  = i_valid && o_ready;
    assign fire    = r_flush && space;
    assign v_next  = (r_seen == SW'(D)) ? SW'(D) : r_seen + 1'b1;
    assign view_v  = r_flush ? r_seen : v_next;
    assign view_j  = r_flush ? r_j : i_kh;

    always_comb begin
        lo = ((SW+1)'(view_j) >= (SW+1)'(i_kh)) ? (SW+1)'(view_j) - (SW+1)'(i_kh) : '0;
        hi = (SW+1)'(view_j) + (SW+1)'(i_kh);
        if (hi > (SW+1)'(view_v) - 1'b1) hi = (SW+1)'(view_v) - 1'b1;
        for (int i = 0; i < D; i++) begin
            sel[i] = ((SW+1)'(i) >= lo) && ((SW+1)'(i) <= hi);
        end
    end

    genvar g;
    generate
        for (g = 0; g < D; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign left[g] = i_row;
            end else begin : g_rest
                assign left[g] = rows[g-1];
            end
            bmr_cell #(.W(W)) u_cell (
                .i_clk       (i_clk),
                .i_shift     (accept),
                .i_push_view (!r_flush),
                .i_sel       (sel[g]),
                .i_mask      (i_mask),
                .i_left      (left[g]),
                .o_row       (rows[g]),
                .o_or        (t_or[g]),
                .o_and       (t_and[g])
            );
        end
    endgenerate

    always_comb begin
        vor  = '0;
        vand = i_mask;
        for (int i = 0; i < D; i++) begin
            vor  = vor | t_or[i];
            vand = vand & t_and[i];
        end
        case (i_kind)
            KIND_ERO:  res = hero(vand, i_kw, i_mask);
            KIND_GRAD: res = hdil(vor, i_kw, i_mask) & ~hero(vand, i_kw, i_mask);
            default:   res = hdil(vor, i_kw, i_mask);
        endcase
        res_last = r_flush ? (r_j == '0) : (i_end && i_kh == '0);
    end

    assign push   = fire || (accept && (v_next > SW'(i_kh)));
    assign pop    = (r_cnt != 2'd0) && i_ready;
    assign wr_idx = (r_cnt == 2'd1) && !pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= '0;
            r_flush <= 1'b0;
            r_j     <= '0;
            r_cnt   <= '0;
        end else begin
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
            if (accept) begin
                r_seen <= (i_end && i_kh == '0) ? '0 : v_next;
                if (i_end && i_kh != '0) begin
                    r_flush <= 1'b1;
                    r_j     <= ((SW+1)'(i_kh) - 1'b1 > (SW+1)'(v_next) - 1'b1)
                               ? KW'(v_next - 1'b1) : i_kh - 1'b1;
                end
            end else if (fire) begin
                if (r_j == '0) begin
                    r_flush <= 1'b0;
                    r_seen  <= '0;
                end else begin
                    r_j <= r_j - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push && !wr_idx) begin
            r_q_row[0]  <= res;
            r_q_last[0] <= res_last;
        end else if (pop) begin
            r_q_row[0]  <= r_q_row[1];
            r_q_last[0] <= r_q_last[1];
        end
        if (push && wr_idx) begin
            r_q_row[1]  <= res;
            r_q_last[1] <= res_last;
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_row   = r_q_row[0];
    assign o_last  = r_q_last[0];

    `BMR_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt != 2'd3)
    `BMR_ASSERT(a_flush_in_window, i_clk, i_rst_n, !r_flush || ((SW+1)'(r_j) < (SW+1)'(r_seen)))
    `BMR_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, accept && i_end && i_kh == '0, r_seen == '0)

endmodule
`default_nettype wire

FILE: src/binary_morphology_rect.sv
// each stage registers its result rows in its output queue
// throughput: 1 row per cycle when not stalled, one filter pass over the cell window
// a frame_end row starts a flush of up to kernel_half_height rows in each stage
// (two stages in close and open), during which no row is accepted
// reset: synchronous active low, clears row counts, flush state, queues and registers
`default_nettype none
module binary_morphology_rect #(
    parameter int MAX_WIDTH       = bmr_pkg::MAX_WIDTH,
    parameter int MAX_HALF_KERNEL = bmr_pkg::MAX_HALF_KERNEL,
    localparam int KW = $clog2(MAX_HALF_KERNEL + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [6:0]           i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [MAX_WIDTH-1:0] i_row_pixels,
    input  wire logic                 i_frame_end,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic      [MAX_WIDTH-1:0] o_result_row,
    output logic                      o_result_last
);
    import bmr_pkg::*;

    localparam int W = MAX_WIDTH;

    logic [2:0] r_op;
    logic [6:0] r_width;
    logic [2:0] r_khw;
    logic [2:0] r_khh;

    logic [W-1:0]  mask;
    logic [KW-1:0] kw, kh;
    t_kind         kind_a, kind_b;
    logic          two;

    logic          a_valid, a_ready, a_last, b_valid, b_ready, b_last, b_in_ready;
    logic [W-1:0]  a_row, b_row;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op    <= OP_DILATE;
            r_width <= 7'd64;
            r_khw   <= 3'd1;
            r_khh   <= 3'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_OP_MODE: r_op    <= i_cfg_data[2:0];
                REG_WIDTH:   r_width <= i_cfg_data;
                REG_KHW:     r_khw   <= i_cfg_data[2:0];
                REG_KHH:     r_khh   <= i_cfg_data[2:0];
                default:     r_op    <= r_op;
            endcase
        end
    end

    always_comb begin
        for (int c = 0; c < W; c++) begin
            mask[c] = (c < int'(r_width));
        end
        kw = (int'(r_khw) > MAX_HALF_KERNEL) ? KW'(MAX_HALF_KERNEL) : KW'(r_khw);
        kh = (int'(r_khh) > MAX_HALF_KERNEL) ? KW'(MAX_HALF_KERNEL) : KW'(r_khh);
        two    = 1'b0;
        kind_b = KIND_DIL;
        case (r_op)
            OP_ERODE:    kind_a = KIND_ERO;
            OP_CLOSE: begin
                kind_a = KIND_DIL;
                kind_b = KIND_ERO;
                two    = 1'b1;
            end
            OP_OPEN: begin
                kind_a = KIND_ERO;
                kind_b = KIND_DIL;
                two    = 1'b1;
            end
            OP_GRADIENT: kind_a = KIND_GRAD;
            default:     kind_a = KIND_DIL;
        endcase
    end

    bmr_stage #(.W(W), .K(MAX_HALF_KERNEL)) u_stage_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_kind  (kind_a),
        .i_mask  (mask),
        .i_kw    (kw),
        .i_kh    (kh),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_row   (i_row_pixels & mask),
        .i_end   (i_frame_end),
        .o_valid (a_valid),
        .i_ready (a_ready),
        .o_row   (a_row),
        .o_last  (a_last)
    );

    bmr_stage #(.W(W), .K(MAX_HALF_KERNEL)) u_stage_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_kind  (kind_b),
        .i_mask  (mask),
        .i_kw    (kw),
        .i_kh    (kh),
        .i_valid (a_valid && two),
        .o_ready (b_in_ready),
        .i_row   (a_row),
        .i_end   (a_last),
        .o_valid (b_valid),
        .i_ready (b_ready),
        .o_row   (b_row),
        .o_last  (b_last)
    );

    assign a_ready       = two ? b_in_ready : i_ready;
    assign b_ready       = two && i_ready;
    assign o_valid       = two ? b_valid : a_valid;
    assign o_result_row  = two ? b_row : a_row;
    assign o_result_last = two ? b_last : a_last;

endmodule
`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import bmr_pkg::*;

    typedef logic [63:0] row_t;
    typedef struct {
        row_t row;
        logic last;
    } res_t;
    typedef struct {
        row_t row;
        logic fend;
        bit   typed;
        row_t exp_row;
    } stim_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index = REG_OP_MODE;
    logic [6:0] i_cfg_data = '0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    row_t       i_row_pixels = '0;
    logic       i_frame_end = 1'b0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    row_t       o_result_row;
    logic       o_result_last;

    binary_morphology_rect dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // model of the block
    logic [2:0] m_op = OP_DILATE;
    logic [6:0] m_width = 7'd64;
    int         m_khw = 1;
    int         m_khh = 1;
    row_t       in_win [15];
    row_t       mid_win[15];
    int         in_seen = 0;
    int         mid_seen = 0;

    res_t  pending_q[$];
    int    n_err = 0;
    int    n_items = 0;
    int    cycles = 0;
    bit    calm = 1'b0;

    function automatic row_t col_mask();
        int w;
        w = (m_width > 64) ? 64 : m_width;
        if (w >= 64) return '1;
        return (row_t'(1) << w) - 1;
    endfunction

    function automatic row_t spread_row(row_t x, int k, row_t m);
        row_t acc;
        acc = x;
        for (int d = 1; d <= k; d++) acc |= (x << d) | (x >> d);
        return acc & m;
    endfunction

    function automatic row_t shrink_row(row_t x, int k, row_t m);
        row_t v, acc;
        v = x | ~m;
        acc = v;
        for (int d = 1; d <= k; d++) begin
            acc &= (v << d) | ((row_t'(1) << d) - 1);
            acc &= (v >> d) | ~(row_t'('1) >> d);
        end
        return acc & m;
    endfunction

    function automatic row_t filter_at(bit use_mid, int v, int j, t_kind kind);
        row_t m, vor, vand, w;
        int lo, hi;
        m = col_mask();
        vor = '0;
        vand = m;
        if (v == 0) return '0;
        lo = (j >= m_khh) ? j - m_khh : 0;
        hi = j + m_khh;
        if (hi > v - 1) hi = v - 1;
        for (int i = lo; i <= hi && i < 15; i++) begin
            w = use_mid ? mid_win[i] : in_win[i];
            vor |= w & m;
            vand &= w;
        end
        if (kind == KIND_DIL) return spread_row(vor, m_khw, m);
        if (kind == KIND_ERO) return shrink_row(vand, m_khw, m);
        return spread_row(vor, m_khw, m) & ~shrink_row(vand, m_khw, m);
    endfunction

    function automatic void shift_in(bit use_mid, row_t row, t_kind kind, ref row_t q[$]);
        int v;
        if (use_mid) begin
            for (int i = 14; i > 0; i--) mid_win[i] = mid_win[i-1];
            mid_win[0] = row;
            if (mid_seen < 15) mid_seen++;
            v = mid_seen;
        end else begin
            for (int i = 14; i > 0; i--) in_win[i] = in_win[i-1];
            in_win[0] = row;
            if (in_seen < 15) in_seen++;
            v = in_seen;
        end
        if (v > m_khh) q.push_back(filter_at(use_mid, v, m_khh, kind));
    endfunction

    function automatic void flush_out(bit use_mid, t_kind kind, ref row_t q[$]);
        int v, top;
        v = use_mid ? mid_seen : in_seen;
        if (v > 0 && m_khh > 0) begin
            top = (m_khh - 1 > v - 1) ? v - 1 : m_khh - 1;
            for (int j = top; j >= 0; j--) q.push_back(filter_at(use_mid, v, j, kind));
        end
        if (use_mid) mid_seen = 0;
        else in_seen = 0;
    endfunction

    function automatic int predict_rows(row_t pix, logic fend);
        row_t  first[$], second[$];
        t_kind k1, k2;
        bit    chain;
        k1 = KIND_DIL;
        k2 = KIND_DIL;
        chain = 1'b0;
        case (m_op)
            OP_ERODE:    k1 = KIND_ERO;
            OP_CLOSE:    begin k2 = KIND_ERO; chain = 1'b1; end
            OP_OPEN:     begin k1 = KIND_ERO; chain = 1'b1; end
            OP_GRADIENT: k1 = KIND_GRAD;
            default:     k1 = KIND_DIL;
        endcase
        shift_in(1'b0, pix & col_mask(), k1, first);
        if (fend) flush_out(1'b0, k1, first);
        if (chain) begin
            foreach (first[i]) shift_in(1'b1, first[i], k2, second);
            if (fend) flush_out(1'b1, k2, second);
            first = second;
        end
        foreach (first[i]) pending_q.push_back('{first[i], fend && i == first.size() - 1});
        return first.size();
    endfunction

    // result side
    always @(posedge i_clk) begin
        i_ready <= calm || ($urandom_range(99) >= 21);
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("RESULT: ERROR");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected item row=%h last=%b",
                                          o_result_row, o_result_last);
            end else begin
                if (o_result_row !== pending_q[0].row || o_result_last !== pending_q[0].last) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch: exp row=%h last=%b got row=%h last=%b",
                                 pending_q[0].row, pending_q[0].last,
                                 o_result_row, o_result_last);
                end
                void'(pending_q.pop_front());
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [6:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_OP_MODE: m_op = val[2:0];
            REG_WIDTH:   m_width = val;
            REG_KHW:     m_khw = val[2:0];
            default:     m_khh = val[2:0];
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic send_row(stim_t s);
        int n;
        i_valid      <= 1'b1;
        i_row_pixels <= s.row;
        i_frame_end  <= s.fend;
        do @(posedge i_clk); while (!o_ready);
        n = predict_rows(s.row, s.fend);
        if (s.typed && n == 1) pending_q[$] = '{s.exp_row, 1'b1};
        n_items++;
        if (!calm && $urandom_range(99) < 21) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    function automatic row_t rand_row();
        case ($urandom_range(5))
            0: return {$urandom, $urandom};
            1: return '0;
            2: return '1;
            3: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            4: return {$urandom, $urandom} | {$urandom, $urandom};
            default: return row_t'(1) << $urandom_range(63);
        endcase
    endfunction

    stim_t directed[] = '{
        '{'1, 1'b1, 1'b1, '1},
        '{'0, 1'b1, 1'b1, '0},
        '{64'h1, 1'b1, 1'b1, 64'h3},
        '{64'h8000_0000_0000_0000, 1'b1, 1'b1, 64'hC000_0000_0000_0000},
        '{64'h1, 1'b0, 1'b0, '0},
        '{64'h8000_0000_0000_0000, 1'b0, 1'b0, '0},
        '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, '0},
        '{64'h5555_5555_5555_5555, 1'b1, 1'b0, '0},
        '{64'hFFFF_0000_FFFF_0000, 1'b1, 1'b1, 64'hFFFF_8001_FFFF_8000}
    };

    initial begin
        logic [2:0] modes[6];
        logic [6:0] widths[6];
        int   phase, nrows;
        stim_t s;
        modes  = '{OP_ERODE, OP_CLOSE, OP_OPEN, OP_GRADIENT, OP_DILATE, 3'd7};
        widths = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd65, 7'd33};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) send_row(directed[i]);
        foreach (modes[i]) begin
            drain();
            write_reg(REG_OP_MODE, 7'(modes[i]));
            for (int r = 0; r < 3; r++) send_row('{rand_row(), r == 2, 1'b0, '0});
        end

        phase = 0;
        while (n_items < 380) begin
            drain();
            calm = (phase == 3);
            write_reg(REG_OP_MODE, 7'($urandom_range(7)));
            write_reg(REG_WIDTH, ($urandom_range(1)) ? widths[$urandom_range(5)]
                                                     : 7'($urandom_range(1, 64)));
            write_reg(REG_KHW, 7'($urandom_range(1) ? $urandom_range(7) : 7 * $urandom_range(1)));
            write_reg(REG_KHH, 7'($urandom_range(1) ? $urandom_range(7) : 7 * $urandom_range(1)));
            for (int f = $urandom_range(1, 4); f > 0; f--) begin
                nrows = $urandom_range(1, 14);
                for (int r = 0; r < nrows; r++) begin
                    s = '{rand_row(), r == nrows - 1, 1'b0, '0};
                    if ($urandom_range(99) < 5) s.fend = 1'b1;
                    send_row(s);
                    // kernel change in the middle of a frame
                    if (r == nrows / 2 && $urandom_range(9) == 0) begin
                        drain();
                        write_reg(REG_KHH, 7'($urandom_range(7)));
                        write_reg(REG_KHW, 7'($urandom_range(7)));
                    end
                end
            end
            phase++;
        end

        drain();
        if (n_err == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+src
src/bmr_pkg.sv
src/bmr_cell.sv
src/bmr_stage.sv
src/binary_morphology_rect.sv
test/testbench.sv
